// File: hw/rtl/sledi_pkg.sv
package sledi_pkg;

    // event kinds on the input stream
    localparam logic [1:0] KIND_TICK    = 2'd0;
    localparam logic [1:0] KIND_SUSPEND = 2'd1;
    localparam logic [1:0] KIND_RESUME  = 2'd2;

    // led commands
    localparam logic [2:0] ACT_NONE       = 3'd0;
    localparam logic [2:0] ACT_SET        = 3'd1;
    localparam logic [2:0] ACT_CLEAR_SET  = 3'd2;
    localparam logic [2:0] ACT_CLEAR_BLINK = 3'd3;
    localparam logic [2:0] ACT_CLEAR      = 3'd4;

    // indicator states
    localparam logic [2:0] IND_NONE     = 3'd0;
    localparam logic [2:0] IND_REST     = 3'd1;
    localparam logic [2:0] IND_RED      = 3'd2;
    localparam logic [2:0] IND_BLUE     = 3'd3;
    localparam logic [2:0] IND_HELD     = 3'd4;

    // suspend nesting limit
    localparam logic [6:0] HOLD_MAX = 7'd127;

    // register indexes
    localparam logic [2:0] REG_RED_HOLD   = 3'd0;
    localparam logic [2:0] REG_RED_LEVEL  = 3'd1;
    localparam logic [2:0] REG_BLUE_LEVEL = 3'd2;
    localparam logic [2:0] REG_IDLE_RED   = 3'd3;
    localparam logic [2:0] REG_IDLE_GREEN = 3'd4;
    localparam logic [2:0] REG_IDLE_BLUE  = 3'd5;

    // register reset values
    localparam logic [23:0] RED_HOLD_RST   = 24'd1500000;
    localparam logic [7:0]  RED_LEVEL_RST  = 8'd255;
    localparam logic [7:0]  BLUE_LEVEL_RST = 8'd200;
    localparam logic [7:0]  IDLE_LEVEL_RST = 8'd0;

    typedef struct packed {
        logic [23:0] red_hold_us;
        logic [7:0]  red_level;
        logic [7:0]  blue_level;
        logic [7:0]  idle_red;
        logic [7:0]  idle_green;
        logic [7:0]  idle_blue;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] now_us;
        logic        flash_active;
        logic        logging_active;
        logic        should_park;
        logic        awake;
        logic        blink_enable;
    } item_t;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [2:0] shown_state;
        logic       short_period;
        logic       state_changed;
    } result_t;

endpackage

// File: hw/rtl/sledi_cfg.sv
module sledi_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output sledi_pkg::cfg_t     cfg
);

    logic [2:0]      reg_index;
    logic            wr_en;
    sledi_pkg::cfg_t cfg_reg;

    assign reg_index = paddr[4:2];
    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    // register writes on the access cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.red_hold_us <= sledi_pkg::RED_HOLD_RST;
            cfg_reg.red_level   <= sledi_pkg::RED_LEVEL_RST;
            cfg_reg.blue_level  <= sledi_pkg::BLUE_LEVEL_RST;
            cfg_reg.idle_red    <= sledi_pkg::IDLE_LEVEL_RST;
            cfg_reg.idle_green  <= sledi_pkg::IDLE_LEVEL_RST;
            cfg_reg.idle_blue   <= sledi_pkg::IDLE_LEVEL_RST;
        end
        else if (wr_en)
        begin
            case (reg_index)
                sledi_pkg::REG_RED_HOLD:   cfg_reg.red_hold_us <= pwdata[23:0];
                sledi_pkg::REG_RED_LEVEL:  cfg_reg.red_level   <= pwdata[7:0];
                sledi_pkg::REG_BLUE_LEVEL: cfg_reg.blue_level  <= pwdata[7:0];
                sledi_pkg::REG_IDLE_RED:   cfg_reg.idle_red    <= pwdata[7:0];
                sledi_pkg::REG_IDLE_GREEN: cfg_reg.idle_green  <= pwdata[7:0];
                sledi_pkg::REG_IDLE_BLUE:  cfg_reg.idle_blue   <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_index)
            sledi_pkg::REG_RED_HOLD:   prdata = {8'd0, cfg_reg.red_hold_us};
            sledi_pkg::REG_RED_LEVEL:  prdata = {24'd0, cfg_reg.red_level};
            sledi_pkg::REG_BLUE_LEVEL: prdata = {24'd0, cfg_reg.blue_level};
            sledi_pkg::REG_IDLE_RED:   prdata = {24'd0, cfg_reg.idle_red};
            sledi_pkg::REG_IDLE_GREEN: prdata = {24'd0, cfg_reg.idle_green};
            sledi_pkg::REG_IDLE_BLUE:  prdata = {24'd0, cfg_reg.idle_blue};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// File: hw/rtl/sledi_core.sv
module sledi_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  sledi_pkg::item_t    item,
    input  sledi_pkg::cfg_t     cfg,
    output sledi_pkg::result_t  res
);

    logic [2:0]  ind_state_reg;
    logic [2:0]  ind_state_next;
    logic [6:0]  hold_count_reg;
    logic [6:0]  hold_count_next;
    logic [47:0] hold_deadline_reg;
    logic [47:0] hold_deadline_next;
    logic        blink_phase_reg;
    logic        blink_phase_next;
    logic        blink_applied_reg;
    logic        blink_applied_next;

    logic [47:0] deadline_sum;
    logic        in_hold;
    logic [2:0]  desired;
    logic        lit;

    // red hold window
    assign deadline_sum = item.now_us + {24'd0, cfg.red_hold_us};
    assign in_hold      = item.now_us < hold_deadline_reg;

    // wanted state by priority
    always_comb
    begin
        if (hold_count_reg != 7'd0)
        begin
            desired = sledi_pkg::IND_HELD;
        end
        else if (item.flash_active || in_hold)
        begin
            desired = sledi_pkg::IND_RED;
        end
        else if (item.logging_active && !item.should_park)
        begin
            desired = sledi_pkg::IND_BLUE;
        end
        else
        begin
            desired = sledi_pkg::IND_REST;
        end
    end

    // next state and result for one event
    always_comb
    begin
        ind_state_next     = ind_state_reg;
        hold_count_next    = hold_count_reg;
        hold_deadline_next = hold_deadline_reg;
        blink_phase_next   = blink_phase_reg;
        blink_applied_next = blink_applied_reg;
        lit                = 1'b1;
        res                = '0;
        res.action         = sledi_pkg::ACT_NONE;
        res.shown_state    = ind_state_reg;

        case (item.kind)
            sledi_pkg::KIND_SUSPEND:
            begin
                if (hold_count_reg == 7'd0)
                begin
                    res.action = sledi_pkg::ACT_CLEAR;
                end
                if (hold_count_reg != sledi_pkg::HOLD_MAX)
                begin
                    hold_count_next = hold_count_reg + 7'd1;
                end
            end
            sledi_pkg::KIND_RESUME:
            begin
                if (hold_count_reg != 7'd0)
                begin
                    hold_count_next = hold_count_reg - 7'd1;
                end
                ind_state_next    = sledi_pkg::IND_NONE;
                res.shown_state   = sledi_pkg::IND_NONE;
                res.state_changed = ind_state_reg != sledi_pkg::IND_NONE;
            end
            sledi_pkg::KIND_TICK:
            begin
                if (hold_count_reg == 7'd0 && item.flash_active)
                begin
                    hold_deadline_next = deadline_sum;
                end
                if (desired != sledi_pkg::IND_HELD && item.awake)
                begin
                    // repaint on state or blink setting change
                    if (desired != ind_state_reg || item.blink_enable != blink_applied_reg)
                    begin
                        blink_phase_next   = 1'b1;
                        blink_applied_next = item.blink_enable;
                        if (desired == sledi_pkg::IND_BLUE && item.blink_enable)
                        begin
                            res.action   = sledi_pkg::ACT_CLEAR_BLINK;
                            res.out_blue = cfg.blue_level;
                        end
                        else
                        begin
                            res.action = sledi_pkg::ACT_CLEAR_SET;
                        end
                    end
                    // blinking red toggles its phase
                    else if (desired == sledi_pkg::IND_RED && item.blink_enable)
                    begin
                        blink_phase_next = !blink_phase_reg;
                        lit              = !blink_phase_reg;
                        res.action       = sledi_pkg::ACT_SET;
                    end
                    // levels for the set actions
                    if (res.action == sledi_pkg::ACT_SET ||
                        res.action == sledi_pkg::ACT_CLEAR_SET)
                    begin
                        if (desired == sledi_pkg::IND_RED)
                        begin
                            res.out_red = lit ? cfg.red_level : 8'd0;
                        end
                        else if (desired == sledi_pkg::IND_BLUE)
                        begin
                            res.out_blue = lit ? cfg.blue_level : 8'd0;
                        end
                        else
                        begin
                            res.out_red   = cfg.idle_red;
                            res.out_green = cfg.idle_green;
                            res.out_blue  = cfg.idle_blue;
                        end
                    end
                end
                ind_state_next    = desired;
                res.shown_state   = desired;
                res.short_period  = desired == sledi_pkg::IND_RED && item.blink_enable;
                res.state_changed = desired != ind_state_reg;
            end
            default:
            begin
            end
        endcase
    end

    // policy state, updated as each event leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ind_state_reg     <= sledi_pkg::IND_NONE;
            hold_count_reg    <= 7'd0;
            hold_deadline_reg <= 48'd0;
            blink_phase_reg   <= 1'b0;
            blink_applied_reg <= 1'b0;
        end
        else if (step)
        begin
            ind_state_reg     <= ind_state_next;
            hold_count_reg    <= hold_count_next;
            hold_deadline_reg <= hold_deadline_next;
            blink_phase_reg   <= blink_phase_next;
            blink_applied_reg <= blink_applied_next;
        end
    end

endmodule

// File: hw/rtl/status_led_indicator_fsm_top.sv
// channel   | dir | handshake           | payload
// ----------+-----+---------------------+-----------------------------------------
// s_*       | in  | s_tvalid / s_tready | event: kind in tuser, time and flags in tdata
// m_*       | out | m_tvalid / m_tready | led command: action in tuser, levels in tdata
// apb       | in  | psel & penable      | six policy registers at 4*index
//
// one event per cycle sustained while results are taken; an event passes from the input
// register into the result register and then sits there until taken.
// the policy state updates as an event moves from the input to the result register.
// a stalled result register holds the next event in the input register; s_tready
// drops only when both are full. rst_n clears state and empties both registers.
module status_led_indicator_fsm_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // now_us, flash_active, logging_active, should_park,
                                   // awake, blink_enable, zero pad
    input  logic [1:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // out_red, out_green, out_blue, shown_state,
                                   // short_period, state_changed, zero pad
    output logic [2:0]  m_tuser,   // action
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    sledi_pkg::cfg_t    cfg;
    sledi_pkg::item_t   in_item_reg;
    sledi_pkg::result_t core_res;
    sledi_pkg::result_t out_res_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               advance;
    logic               in_take;

    sledi_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sledi_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    // pipeline flow
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg.kind           <= s_tuser;
            in_item_reg.now_us         <= s_tdata[47:0];
            in_item_reg.flash_active   <= s_tdata[48];
            in_item_reg.logging_active <= s_tdata[49];
            in_item_reg.should_park    <= s_tdata[50];
            in_item_reg.awake          <= s_tdata[51];
            in_item_reg.blink_enable   <= s_tdata[52];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    // result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tdata  = {3'd0,
                       out_res_reg.state_changed,
                       out_res_reg.short_period,
                       out_res_reg.shown_state,
                       out_res_reg.out_blue,
                       out_res_reg.out_green,
                       out_res_reg.out_red};

endmodule

// File: hw/rtl/sledi_checker.sv
module sledi_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // hardware blink only in the logging state with red and green off
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == sledi_pkg::ACT_CLEAR_BLINK |->
            m_tdata[26:24] == sledi_pkg::IND_BLUE && m_tdata[15:0] == 16'd0)
        else $error("blink command outside logging state");

    // short period only while red
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27] |-> m_tdata[26:24] == sledi_pkg::IND_RED)
        else $error("fast tick outside red state");

    // plain level update is a red blink toggle without a state change
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == sledi_pkg::ACT_SET |->
            m_tdata[26:24] == sledi_pkg::IND_RED && m_tdata[27] && !m_tdata[28])
        else $error("level update outside red blink");

    // clear only comes from a suspend and carries no levels
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == sledi_pkg::ACT_CLEAR |->
            m_tdata[28:0] == {2'd0, m_tdata[26:24], 24'd0})
        else $error("clear command with levels or flags");

endmodule

bind status_led_indicator_fsm_top sledi_checker u_sledi_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: dv/tb.sv
module tb;

    // short names for the event kinds in the table
    localparam logic [1:0] EV_TICK    = sledi_pkg::KIND_TICK;
    localparam logic [1:0] EV_SUSPEND = sledi_pkg::KIND_SUSPEND;
    localparam logic [1:0] EV_RESUME  = sledi_pkg::KIND_RESUME;
    // kind value with no meaning, the block passes it through
    localparam logic [1:0] EV_UNUSED  = 2'd3;

    typedef struct packed {
        sledi_pkg::item_t   ev;
        logic               known;
        sledi_pkg::result_t lit;
    } step_row_t;

    localparam sledi_pkg::result_t NO_LIT = '0;
    localparam int DIRECTED_ROWS = 21;

    // directed table: kind, now_us, flash, logging, park, awake, blink
    localparam step_row_t DIRECTED [DIRECTED_ROWS] = '{
        // first tick after reset paints the idle color
        '{'{EV_TICK, 48'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b1,
          '{sledi_pkg::ACT_CLEAR_SET, 8'd0, 8'd0, 8'd0, sledi_pkg::IND_REST, 1'b0, 1'b1}},
        // flash activity with blinking, phase on
        '{'{EV_TICK, 48'd1000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1,
          '{sledi_pkg::ACT_CLEAR_SET, 8'd255, 8'd0, 8'd0, sledi_pkg::IND_RED, 1'b1, 1'b1}},
        // red held after activity, phase toggles off
        '{'{EV_TICK, 48'd2000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b1,
          '{sledi_pkg::ACT_SET, 8'd0, 8'd0, 8'd0, sledi_pkg::IND_RED, 1'b1, 1'b0}},
        '{'{EV_TICK, 48'd2001, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_LIT},
        // blink setting change repaints solid
        '{'{EV_TICK, 48'd3000, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_LIT},
        // hold expires exactly at the deadline
        '{'{EV_TICK, 48'd1501000, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_LIT},
        // hardware blue blink
        '{'{EV_TICK, 48'd1501001, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, NO_LIT},
        // parked logging falls back to idle
        '{'{EV_TICK, 48'd1501002, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_LIT},
        // not awake: state moves, nothing painted
        '{'{EV_TICK, 48'd1600000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}, 1'b0, NO_LIT},
        // nested suspends
        '{'{EV_SUSPEND, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{EV_SUSPEND, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_LIT},
        '{'{EV_TICK, 48'd1600001, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, NO_LIT},
        '{'{EV_RESUME, 48'd0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_LIT},
        '{'{EV_RESUME, 48'd5, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_LIT},
        // resume with nothing held stays at zero
        '{'{EV_RESUME, 48'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_LIT},
        '{'{EV_UNUSED, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_LIT},
        // deadline wraps past the top of the time range
        '{'{EV_TICK, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1}, 1'b0, NO_LIT},
        '{'{EV_TICK, 48'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_LIT},
        '{'{EV_TICK, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_LIT},
        '{'{EV_UNUSED, 48'hAAAA_AAAA_AAAA, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0}, 1'b0, NO_LIT},
        '{'{EV_TICK, 48'h5555_5555_5555, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1}, 1'b0, NO_LIT}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;  // now_us, flash_active, logging_active, should_park,
                                // awake, blink_enable, zero pad
    logic [1:0]  s_tuser = '0;  // kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;       // out_red, out_green, out_blue, shown_state,
                                // short_period, state_changed, zero pad
    logic [2:0]  m_tuser;       // action
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // predicted policy state and registers
    sledi_pkg::cfg_t led_cfg;
    logic [2:0]      lamp_state;
    logic [6:0]      suspend_depth;
    logic [47:0]     red_until;
    logic            blink_lit;
    logic            blink_mode;

    sledi_pkg::result_t pending_cmds[$];
    int          sender_idle_pct = 0;
    int          ready_stall_pct = 0;
    int          mismatch_cnt = 0;
    int          checked_cnt = 0;
    int          sent_cnt = 0;
    logic [47:0] now_cursor = '0;
    logic        blink_pref = 1'b0;

    status_led_indicator_fsm_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #2000000;
        $display("[status_led_indicator_fsm_top] ERROR");
        $finish;
    end

    // levels packed as blue, green, red
    function automatic logic [23:0] lamp_levels(input logic [2:0] st, input logic on);
        if (st == sledi_pkg::IND_RED)
            return {16'd0, on ? led_cfg.red_level : 8'd0};
        else if (st == sledi_pkg::IND_BLUE)
            return {on ? led_cfg.blue_level : 8'd0, 16'd0};
        else
            return {led_cfg.idle_blue, led_cfg.idle_green, led_cfg.idle_red};
    endfunction

    // next led command and state update for one event
    function automatic sledi_pkg::result_t predict_led_command(input sledi_pkg::item_t ev);
        sledi_pkg::result_t res;
        logic [2:0]         prev;
        logic [2:0]         want;
        logic [23:0]        rgb;
        res = '0;
        rgb = '0;
        prev = lamp_state;
        if (ev.kind == sledi_pkg::KIND_SUSPEND)
        begin
            if (suspend_depth == 7'd0)
                res.action = sledi_pkg::ACT_CLEAR;
            if (suspend_depth < sledi_pkg::HOLD_MAX)
                suspend_depth = suspend_depth + 7'd1;
            res.shown_state = lamp_state;
        end
        else if (ev.kind == sledi_pkg::KIND_RESUME)
        begin
            if (suspend_depth != 7'd0)
                suspend_depth = suspend_depth - 7'd1;
            lamp_state = sledi_pkg::IND_NONE;
            res.shown_state = sledi_pkg::IND_NONE;
            res.state_changed = (prev != sledi_pkg::IND_NONE);
        end
        else if (ev.kind == sledi_pkg::KIND_TICK)
        begin
            // wanted state by priority
            if (suspend_depth != 7'd0)
                want = sledi_pkg::IND_HELD;
            else if (ev.flash_active)
            begin
                want = sledi_pkg::IND_RED;
                red_until = ev.now_us + {24'd0, led_cfg.red_hold_us};
            end
            else if (ev.now_us < red_until)
                want = sledi_pkg::IND_RED;
            else if (ev.logging_active && !ev.should_park)
                want = sledi_pkg::IND_BLUE;
            else
                want = sledi_pkg::IND_REST;

            // repaint on change, toggle phase while blinking red
            if (want != sledi_pkg::IND_HELD && ev.awake)
            begin
                if (want != prev || ev.blink_enable != blink_mode)
                begin
                    blink_lit = 1'b1;
                    if (want == sledi_pkg::IND_BLUE && ev.blink_enable)
                    begin
                        res.action = sledi_pkg::ACT_CLEAR_BLINK;
                        res.out_blue = led_cfg.blue_level;
                    end
                    else
                    begin
                        res.action = sledi_pkg::ACT_CLEAR_SET;
                        rgb = lamp_levels(want, blink_lit);
                    end
                    blink_mode = ev.blink_enable;
                end
                else if (want == sledi_pkg::IND_RED && ev.blink_enable)
                begin
                    blink_lit = ~blink_lit;
                    res.action = sledi_pkg::ACT_SET;
                    rgb = lamp_levels(want, blink_lit);
                end
            end
            if (res.action != sledi_pkg::ACT_CLEAR_BLINK)
            begin
                res.out_red = rgb[7:0];
                res.out_green = rgb[15:8];
                res.out_blue = rgb[23:16];
            end
            lamp_state = want;
            res.shown_state = want;
            res.short_period = (want == sledi_pkg::IND_RED) && ev.blink_enable;
            res.state_changed = (want != prev);
        end
        else
            res.shown_state = lamp_state;
        return res;
    endfunction

    // one register write: setup phase, access phase, then idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sledi_pkg::REG_RED_HOLD:   led_cfg.red_hold_us = value[23:0];
            sledi_pkg::REG_RED_LEVEL:  led_cfg.red_level = value[7:0];
            sledi_pkg::REG_BLUE_LEVEL: led_cfg.blue_level = value[7:0];
            sledi_pkg::REG_IDLE_RED:   led_cfg.idle_red = value[7:0];
            sledi_pkg::REG_IDLE_GREEN: led_cfg.idle_green = value[7:0];
            sledi_pkg::REG_IDLE_BLUE:  led_cfg.idle_blue = value[7:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic program_policy(input logic [23:0] hold, input logic [7:0] red,
                                  input logic [7:0] blue, input logic [7:0] ir,
                                  input logic [7:0] ig, input logic [7:0] ib);
        write_reg(sledi_pkg::REG_RED_HOLD, {8'd0, hold});
        write_reg(sledi_pkg::REG_RED_LEVEL, {24'd0, red});
        write_reg(sledi_pkg::REG_BLUE_LEVEL, {24'd0, blue});
        write_reg(sledi_pkg::REG_IDLE_RED, {24'd0, ir});
        write_reg(sledi_pkg::REG_IDLE_GREEN, {24'd0, ig});
        write_reg(sledi_pkg::REG_IDLE_BLUE, {24'd0, ib});
    endtask

    // send one event, predict its command once the transfer happens
    task automatic push_event(input sledi_pkg::item_t ev, input logic use_lit,
                              input sledi_pkg::result_t lit);
        sledi_pkg::result_t model_cmd;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= ev.kind;
        s_tdata <= {3'b000, ev.blink_enable, ev.awake, ev.should_park,
                    ev.logging_active, ev.flash_active, ev.now_us};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        model_cmd = predict_led_command(ev);
        pending_cmds.push_back(use_lit ? lit : model_cmd);
        sent_cnt++;
    endtask

    // mostly ticks on a moving time line, with suspends, resumes and noise
    task automatic next_random_event(output sledi_pkg::item_t ev);
        int unsigned pick;
        int unsigned span;
        pick = $urandom_range(99);
        span = led_cfg.red_hold_us / 3 + 2;
        ev.now_us = 48'({$urandom, $urandom});
        ev.flash_active = 1'($urandom_range(1));
        ev.logging_active = 1'($urandom_range(1));
        ev.should_park = 1'($urandom_range(1));
        ev.awake = 1'($urandom_range(1));
        ev.blink_enable = 1'($urandom_range(1));
        if (pick < 8)
            ev.kind = EV_SUSPEND;
        else if (pick < 16)
            ev.kind = EV_RESUME;
        else if (pick < 18)
            ev.kind = EV_UNUSED;
        else
        begin
            ev.kind = EV_TICK;
            if (pick < 22)
                now_cursor = ev.now_us;
            else if (pick < 25)
                now_cursor = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(span));
            else
                now_cursor = now_cursor + 48'($urandom_range(span));
            if ($urandom_range(99) < 15)
                blink_pref = ~blink_pref;
            ev.now_us = now_cursor;
            ev.flash_active = ($urandom_range(99) < 25);
            ev.logging_active = ($urandom_range(99) < 60);
            ev.should_park = ($urandom_range(99) < 25);
            ev.awake = ($urandom_range(99) < 90);
            ev.blink_enable = blink_pref;
        end
    endtask

    // receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= ready_stall_pct);

    // compare each led command transfer with the oldest prediction
    always @(posedge clk)
    begin : check_cmd
        sledi_pkg::result_t got;
        sledi_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.action = m_tuser;
            got.out_red = m_tdata[7:0];
            got.out_green = m_tdata[15:8];
            got.out_blue = m_tdata[23:16];
            got.shown_state = m_tdata[26:24];
            got.short_period = m_tdata[27];
            got.state_changed = m_tdata[28];
            if (pending_cmds.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("tb: led command with none expected: act=%0d st=%0d",
                             got.action, got.shown_state);
            end
            else
            begin
                want = pending_cmds.pop_front();
                checked_cnt++;
                if (got !== want)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                    begin
                        $display("tb: mismatch at command %0d", checked_cnt);
                        $display("tb:   expected act=%0d r=%0d g=%0d b=%0d st=%0d %s%0b %s%0b",
                                 want.action, want.out_red, want.out_green,
                                 want.out_blue, want.shown_state, "fast=",
                                 want.short_period, "chg=", want.state_changed);
                        $display("tb:   got      act=%0d r=%0d g=%0d b=%0d st=%0d %s%0b %s%0b",
                                 got.action, got.out_red, got.out_green,
                                 got.out_blue, got.shown_state, "fast=",
                                 got.short_period, "chg=", got.state_changed);
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        sledi_pkg::item_t ev;
        int               round;
        int               i;

        led_cfg = '{sledi_pkg::RED_HOLD_RST, sledi_pkg::RED_LEVEL_RST,
                    sledi_pkg::BLUE_LEVEL_RST, sledi_pkg::IDLE_LEVEL_RST,
                    sledi_pkg::IDLE_LEVEL_RST, sledi_pkg::IDLE_LEVEL_RST};
        lamp_state = sledi_pkg::IND_NONE;
        suspend_depth = '0;
        red_until = '0;
        blink_lit = 1'b0;
        blink_mode = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed table at reset settings
        for (i = 0; i < DIRECTED_ROWS; i++)
            push_event(DIRECTED[i].ev, DIRECTED[i].known, DIRECTED[i].lit);

        for (round = 0; round < 4; round++)
        begin
            s_tvalid <= 1'b0;
            while (pending_cmds.size() != 0)
                @(posedge clk);
            case (round)
                0:
                begin
                    sender_idle_pct = 0;
                    ready_stall_pct = 0;
                    program_policy(24'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255);
                end
                1:
                begin
                    sender_idle_pct = 67;
                    ready_stall_pct = 0;
                    program_policy(24'hFF_FFFF, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0);
                end
                2:
                begin
                    sender_idle_pct = 0;
                    ready_stall_pct = 67;
                    program_policy(24'($urandom_range(1, 5000)), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom));
                end
                default:
                begin
                    sender_idle_pct = 27;
                    ready_stall_pct = 27;
                    program_policy(24'($urandom_range(0, 2000000)), 8'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom));
                end
            endcase

            // suspend nesting past saturation and back down to zero
            if (round == 0)
            begin
                for (i = 0; i < 260; i++)
                begin
                    next_random_event(ev);
                    ev.kind = (i < 129) ? EV_SUSPEND :
                              (i == 129 || i == 259) ? EV_TICK : EV_RESUME;
                    push_event(ev, 1'b0, NO_LIT);
                end
            end

            repeat (42)
            begin
                next_random_event(ev);
                push_event(ev, 1'b0, NO_LIT);
            end
        end

        // drain
        s_tvalid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        $display("tb: %0d events sent, %0d led commands checked, %0d mismatches",
                 sent_cnt, checked_cnt, mismatch_cnt);
        $display("tb: four idling mixes, register extremes and suspend saturation covered");
        if (mismatch_cnt == 0 && pending_cmds.size() == 0)
            $display("[status_led_indicator_fsm_top] OK");
        else
            $display("[status_led_indicator_fsm_top] ERROR");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/sledi_pkg.sv
hw/rtl/sledi_cfg.sv
hw/rtl/sledi_core.sv
hw/rtl/status_led_indicator_fsm_top.sv
hw/rtl/sledi_checker.sv
dv/tb.sv
